// ===== rtl/maze_wall_union_find_unit_defines.svh =====
// Assertion macros for the maze wall union-find unit.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef MAZE_WALL_UNION_FIND_UNIT_DEFINES_SVH
`define MAZE_WALL_UNION_FIND_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define MWUF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent
`define MWUF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mwuf_pkg.sv =====
package mwuf_pkg;

	// Default room array size
	localparam int unsigned MAX_ROOM_ROWS_DEF = 32;
	localparam int unsigned MAX_ROOM_COLS_DEF = 32;

	// Grid coordinate and rank widths
	localparam int unsigned COORD_W = 7;
	localparam int unsigned HALF_W  = COORD_W - 1;
	localparam int unsigned RANK_W  = 4;
	localparam logic [RANK_W-1:0]  RANK_MAX      = 4'd15;
	localparam logic [COORD_W-1:0] GRID_SIZE_RST = 7'd65;

	// Configuration register indexes
	typedef enum logic {
		CFG_GRID_ROWS = 1'b0,
		CFG_GRID_COLS = 1'b1
	} cfg_idx_t;

	// Result codes
	typedef enum logic [1:0] {
		OUT_JOINED    = 2'd0,
		OUT_CONNECTED = 2'd1,
		OUT_NOT_WALL  = 2'd2
	} outcome_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;     // write one clear entry and advance the sweep
		logic load;      // capture the request coordinates
		logic classify;  // check position, form room halves and cell address
		logic rooms;     // form both room indexes
		logic start_a;   // begin the walk from room A
		logic step;      // follow the parent just read
		logic root_a;    // hold root A, begin the walk from room B
		logic root_b;    // hold root B
		logic unite;     // link roots, bump rank, open wall
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic legal;
		logic wall_open;
		logic at_root;
		logic same_root;
	} dp_stat_t;

	// Clamp a grid size register to 3 .. max, then make it odd
	function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] v,
		input int unsigned max_size);
		int unsigned s;
		s = v;
		if (s < 3) s = 3;
		if (s > max_size) s = max_size;
		if (s[0] == 1'b0) s = s - 1;
		return s[COORD_W-1:0];
	endfunction

	// Address width for a store of the given depth
	function automatic int unsigned idx_width(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== rtl/mwuf_dp.sv =====
module mwuf_dp #(
	parameter int unsigned MAX_ROOM_ROWS = 32,
	parameter int unsigned MAX_ROOM_COLS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [6:0]          cfg_wdata,
	input  logic [6:0]          wall_row,
	input  logic [6:0]          wall_col,
	input  mwuf_pkg::dp_cmd_t   cmd,
	output mwuf_pkg::dp_stat_t  stat
);
	import mwuf_pkg::*;

	localparam int unsigned ROOM_COUNT = MAX_ROOM_ROWS * MAX_ROOM_COLS;
	localparam int unsigned GRID_ROWS  = 2 * MAX_ROOM_ROWS + 1;
	localparam int unsigned GRID_COLS  = 2 * MAX_ROOM_COLS + 1;
	localparam int unsigned CELL_COUNT = GRID_ROWS * GRID_COLS;
	localparam int unsigned RW         = idx_width(ROOM_COUNT);
	localparam int unsigned CELLW      = idx_width(CELL_COUNT);
	localparam int unsigned PRODW      = 2 * HALF_W + 1;

	// Configuration registers
	logic [COORD_W-1:0] grid_rows_q, grid_cols_q;
	logic [COORD_W-1:0] rows_eff, cols_eff;

	// Request and derived values
	logic [COORD_W-1:0] row_q, col_q;
	logic               legal_q;
	logic [HALF_W-1:0]  ar_h_q, ac_h_q, br_h_q, bc_h_q, colh_q;
	logic [CELLW-1:0]   cell_q;
	logic [RW-1:0]      room_a_q, room_b_q;

	// Walk state
	logic [RW-1:0]      cur_q, root_a_q, root_b_q;
	logic [RANK_W-1:0]  rank_a_q, rank_b_q;

	// Clear sweep
	logic [CELLW-1:0]   clr_q;
	logic               clr_room;

	// Stores
	logic [RW-1:0]      parent_mem [ROOM_COUNT];
	logic [RANK_W-1:0]  rank_mem   [ROOM_COUNT];
	logic               wall_mem   [CELL_COUNT];

	logic [RW-1:0]      par_rd_q;
	logic [RANK_W-1:0]  rank_rd_q;
	logic               wall_rd_q;

	logic [RW-1:0]      par_ra, par_wa, par_wd, rank_wa;
	logic               par_we, rank_we, wall_we, wall_wd;
	logic [RANK_W-1:0]  rank_wd;
	logic [CELLW-1:0]   wall_wa;

	// Classification of the held position
	logic               horiz, vert, in_grid;
	logic [COORD_W-1:0] row_m1, row_p1, col_m1, col_p1;
	logic [CELLW-1:0]   cell_addr;
	logic [PRODW-1:0]   room_a_full, room_b_full;

	assign rows_eff = eff_size(grid_rows_q, GRID_ROWS);
	assign cols_eff = eff_size(grid_cols_q, GRID_COLS);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_SIZE_RST;
			grid_cols_q <= GRID_SIZE_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_GRID_ROWS) grid_rows_q <= cfg_wdata;
			else grid_cols_q <= cfg_wdata;
		end
	end

	// Advance the clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + CELLW'(1);
		end
	end

	assign clr_room = (clr_q < CELLW'(ROOM_COUNT));

	// Classify the wall position
	always_comb begin
		horiz  = row_q[0] & ~col_q[0];
		vert   = ~row_q[0] & col_q[0];
		in_grid = (row_q < rows_eff) && (col_q < cols_eff) &&
			(row_q != '0) && (col_q != '0) &&
			(row_q != rows_eff - 7'd1) && (col_q != cols_eff - 7'd1);
		row_m1 = row_q - 7'd1;
		row_p1 = row_q + 7'd1;
		col_m1 = col_q - 7'd1;
		col_p1 = col_q + 7'd1;
		cell_addr = CELLW'(int'(row_q) * GRID_COLS + int'(col_q));
		room_a_full = PRODW'(ar_h_q) * PRODW'(colh_q) + PRODW'(ac_h_q);
		room_b_full = PRODW'(br_h_q) * PRODW'(colh_q) + PRODW'(bc_h_q);
	end

	// Hold request and derived values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= wall_row;
			col_q <= wall_col;
		end
		if (cmd.classify) begin
			legal_q <= in_grid & (horiz | vert);
			ar_h_q  <= horiz ? row_q[COORD_W-1:1]  : row_m1[COORD_W-1:1];
			br_h_q  <= horiz ? row_q[COORD_W-1:1]  : row_p1[COORD_W-1:1];
			ac_h_q  <= horiz ? col_m1[COORD_W-1:1] : col_q[COORD_W-1:1];
			bc_h_q  <= horiz ? col_p1[COORD_W-1:1] : col_q[COORD_W-1:1];
			colh_q  <= cols_eff[COORD_W-1:1];
			cell_q  <= (in_grid & (horiz | vert)) ? cell_addr : '0;
		end
		if (cmd.rooms) begin
			room_a_q <= RW'(room_a_full);
			room_b_q <= RW'(room_b_full);
		end
		if (cmd.start_a) cur_q <= room_a_q;
		else if (cmd.root_a) cur_q <= room_b_q;
		else if (cmd.step) cur_q <= par_rd_q;
		if (cmd.root_a) begin
			root_a_q <= cur_q;
			rank_a_q <= rank_rd_q;
		end
		if (cmd.root_b) begin
			root_b_q <= cur_q;
			rank_b_q <= rank_rd_q;
		end
	end

	// Select parent read address
	always_comb begin
		if (cmd.root_a) par_ra = room_b_q;
		else if (cmd.step) par_ra = par_rd_q;
		else par_ra = room_a_q;
	end

	// Select store writes: clear sweep or union
	always_comb begin
		par_we  = 1'b0;
		par_wa  = clr_q[RW-1:0];
		par_wd  = clr_q[RW-1:0];
		rank_we = 1'b0;
		rank_wa = clr_q[RW-1:0];
		rank_wd = '0;
		wall_we = 1'b0;
		wall_wa = clr_q;
		wall_wd = 1'b0;
		if (cmd.clear) begin
			par_we  = clr_room;
			rank_we = clr_room;
			wall_we = 1'b1;
		end else if (cmd.unite) begin
			par_we = 1'b1;
			if (rank_a_q < rank_b_q) begin
				par_wa = root_a_q;
				par_wd = root_b_q;
			end else begin
				par_wa = root_b_q;
				par_wd = root_a_q;
			end
			rank_we = (rank_a_q == rank_b_q);
			rank_wa = root_a_q;
			rank_wd = (rank_a_q == RANK_MAX) ? RANK_MAX : rank_a_q + 4'd1;
			wall_we = 1'b1;
			wall_wa = cell_q;
			wall_wd = 1'b1;
		end
	end

	// Room stores: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (par_we) parent_mem[par_wa] <= par_wd;
		if (rank_we) rank_mem[rank_wa] <= rank_wd;
		par_rd_q  <= parent_mem[par_ra];
		rank_rd_q <= rank_mem[par_ra];
	end

	// Wall store
	always_ff @(posedge clk) begin
		if (wall_we) wall_mem[wall_wa] <= wall_wd;
		wall_rd_q <= wall_mem[cell_q];
	end

	// Report status
	always_comb begin
		stat.clear_last = (clr_q == CELLW'(CELL_COUNT - 1));
		stat.legal      = legal_q;
		stat.wall_open  = wall_rd_q;
		stat.at_root    = (par_rd_q == cur_q);
		stat.same_root  = (cur_q == root_a_q);
	end

endmodule

// ===== rtl/mwuf_ctrl.sv =====
module mwuf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mwuf_pkg::dp_stat_t  stat,
	output mwuf_pkg::dp_cmd_t   cmd,
	output logic                busy,
	output logic                done,
	output mwuf_pkg::outcome_t  outcome
);
	import mwuf_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_ROOMS,
		ST_WCHK,
		ST_WALK_A,
		ST_WALK_B,
		ST_UNITE
	} state_t;

	state_t   state_q;
	logic     done_q;
	outcome_t outcome_q;

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign outcome = outcome_q;

	// Drive datapath commands from state and status
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clear    = 1'b1;
			ST_IDLE:   cmd.load     = start;
			ST_CHECK:  cmd.classify = 1'b1;
			ST_ROOMS:  cmd.rooms    = 1'b1;
			ST_WCHK:   cmd.start_a  = stat.legal & ~stat.wall_open;
			ST_WALK_A: begin
				cmd.root_a = stat.at_root;
				cmd.step   = ~stat.at_root;
			end
			ST_WALK_B: begin
				cmd.root_b = stat.at_root;
				cmd.step   = ~stat.at_root;
			end
			ST_UNITE:  cmd.unite    = 1'b1;
			default:   cmd = '0;
		endcase
	end

	// Check a request, then walk both roots and unite as needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			done_q    <= 1'b0;
			outcome_q <= OUT_NOT_WALL;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) state_q <= ST_CHECK;
				end
				ST_CHECK: state_q <= ST_ROOMS;
				ST_ROOMS: state_q <= ST_WCHK;
				ST_WCHK: begin
					if (!stat.legal || stat.wall_open) begin
						done_q    <= 1'b1;
						outcome_q <= OUT_NOT_WALL;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_WALK_A;
					end
				end
				ST_WALK_A: begin
					if (stat.at_root) state_q <= ST_WALK_B;
				end
				ST_WALK_B: begin
					if (stat.at_root) begin
						if (stat.same_root) begin
							done_q    <= 1'b1;
							outcome_q <= OUT_CONNECTED;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_UNITE;
						end
					end
				end
				ST_UNITE: begin
					done_q    <= 1'b1;
					outcome_q <= OUT_JOINED;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/maze_wall_union_find_unit.sv =====
// Sequence: a request that is not a closed wall strobes done after the position and wall checks;
// otherwise the unit walks the parent chains of room A and then room B, one parent read per step,
// and strobes done as connected when the roots match, or as joined after linking the roots.
// Requests: one at a time; the next request may be taken in the done cycle.
// Reset: a clearing pass over (2*MAX_ROOM_ROWS+1)*(2*MAX_ROOM_COLS+1) cells (4225 by default)
// follows reset with busy high; the done strobe lasts one cycle and the receiver cannot stall.
module maze_wall_union_find_unit #(
	parameter int unsigned MAX_ROOM_ROWS = mwuf_pkg::MAX_ROOM_ROWS_DEF,
	parameter int unsigned MAX_ROOM_COLS = mwuf_pkg::MAX_ROOM_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [6:0] wall_row,
	input  logic [6:0] wall_col,
	output logic       done,
	output logic [1:0] outcome,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [6:0] cfg_wdata
);
	import mwuf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	outcome_t outcome_code;

	assign outcome = outcome_code;

	mwuf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.outcome (outcome_code)
	);

	mwuf_dp #(
		.MAX_ROOM_ROWS (MAX_ROOM_ROWS),
		.MAX_ROOM_COLS (MAX_ROOM_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.wall_row  (wall_row),
		.wall_col  (wall_col),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/mwuf_checker.sv =====
`include "maze_wall_union_find_unit_defines.svh"

module mwuf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] outcome
);

	// An accepted request keeps the block busy in the next cycle
	`MWUF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

	// A result only comes out of a request in progress
	`MWUF_ASSERT_SAME(a_done_after_busy, done, !busy && $past(busy), "done without work")

	// One strobe per request
	`MWUF_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")

	// Only the three result codes are reported
	`MWUF_ASSERT_SAME(a_outcome_code, done, outcome != 2'd3, "undefined outcome code")

endmodule

bind maze_wall_union_find_unit mwuf_checker u_mwuf_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Tracks the expected outcome of every accepted request with its own copy of
// the room forest, the rank store and the open-wall map.
class wall_scoreboard;
	localparam int ROOM_ROWS = mwuf_pkg::MAX_ROOM_ROWS_DEF;
	localparam int ROOM_COLS = mwuf_pkg::MAX_ROOM_COLS_DEF;
	localparam int ROOMS = ROOM_ROWS * ROOM_COLS;
	localparam int GRID_ROWS_MAX = 2 * ROOM_ROWS + 1;
	localparam int GRID_COLS_MAX = 2 * ROOM_COLS + 1;
	localparam int CELLS = GRID_ROWS_MAX * GRID_COLS_MAX;

	bit [6:0] rows_reg;
	bit [6:0] cols_reg;
	bit [9:0] parent [ROOMS];
	bit [3:0] rank [ROOMS];
	bit open_cell [CELLS];
	mwuf_pkg::outcome_t outcome_q [$];
	int errors;

	function new();
		rows_reg = mwuf_pkg::GRID_SIZE_RST;
		cols_reg = mwuf_pkg::GRID_SIZE_RST;
		for (int i = 0; i < ROOMS; i++) begin
			parent[i] = 10'(i);
			rank[i] = '0;
		end
		for (int i = 0; i < CELLS; i++) begin
			open_cell[i] = 1'b0;
		end
		errors = 0;
	endfunction

	// Clamp a size register into the legal range and force it odd
	function int grid_size(bit [6:0] v, int max_size);
		int s;
		s = v;
		if (s < 3) s = 3;
		if (s > max_size) s = max_size;
		if (s % 2 == 0) s = s - 1;
		return s;
	endfunction

	// Walk parent links up to the set root, no compression
	function int find_root(int room);
		int x;
		x = room;
		for (int n = 0; n < ROOMS; n++) begin
			if (int'(parent[x]) == x) break;
			x = parent[x];
		end
		return x;
	endfunction

	function void note_config(logic idx, bit [6:0] v);
		if (idx == mwuf_pkg::CFG_GRID_ROWS) rows_reg = v;
		else cols_reg = v;
	endfunction

	// Predict the outcome of one wall request and update the forest
	function void note_request(bit [6:0] wr, bit [6:0] wc);
		int rows, cols, r, c, room_a, room_b, ra, rb, cell_idx;
		bit legal;
		mwuf_pkg::outcome_t res;
		rows = grid_size(rows_reg, GRID_ROWS_MAX);
		cols = grid_size(cols_reg, GRID_COLS_MAX);
		r = wr;
		c = wc;
		res = mwuf_pkg::OUT_NOT_WALL;
		legal = 1'b0;
		room_a = 0;
		room_b = 0;
		if (r < rows && c < cols && r != 0 && c != 0 && r != rows - 1 && c != cols - 1) begin
			if (r % 2 == 1 && c % 2 == 0) begin
				// wall between left and right rooms
				legal = 1'b1;
				room_a = (r / 2) * (cols / 2) + (c - 1) / 2;
				room_b = (r / 2) * (cols / 2) + (c + 1) / 2;
			end else if (r % 2 == 0 && c % 2 == 1) begin
				// wall between upper and lower rooms
				legal = 1'b1;
				room_a = ((r - 1) / 2) * (cols / 2) + c / 2;
				room_b = ((r + 1) / 2) * (cols / 2) + c / 2;
			end
		end
		cell_idx = r * GRID_COLS_MAX + c;
		if (legal && !open_cell[cell_idx]) begin
			ra = find_root(room_a);
			rb = find_root(room_b);
			if (ra == rb) begin
				res = mwuf_pkg::OUT_CONNECTED;
			end else begin
				// open the wall and link the lower-ranked root under the other, B under A on a tie
				open_cell[cell_idx] = 1'b1;
				if (rank[ra] < rank[rb]) begin
					parent[ra] = 10'(rb);
				end else if (rank[ra] > rank[rb]) begin
					parent[rb] = 10'(ra);
				end else begin
					parent[rb] = 10'(ra);
					if (rank[ra] != mwuf_pkg::RANK_MAX) rank[ra] = rank[ra] + 4'd1;
				end
				res = mwuf_pkg::OUT_JOINED;
			end
		end
		outcome_q.push_back(res);
	endfunction

	function void check_outcome(logic [1:0] got);
		mwuf_pkg::outcome_t want;
		if (outcome_q.size() == 0) begin
			$error("outcome: expected none, actual %0d", got);
			errors++;
			return;
		end
		want = outcome_q.pop_front();
		if (got !== want) begin
			$error("outcome: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction

	function int pending();
		return outcome_q.size();
	endfunction
endclass

module testbench;
	import mwuf_pkg::*;

	// Covers the clearing pass after reset with a wide margin
	localparam int IDLE_LIMIT = 20000;
	localparam int GRID_ROWS_LIM = 2 * MAX_ROOM_ROWS_DEF + 1;
	localparam int GRID_COLS_LIM = 2 * MAX_ROOM_COLS_DEF + 1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [6:0] wall_row;
	logic [6:0] wall_col;
	logic done;
	logic [1:0] outcome;
	logic cfg_we;
	logic cfg_idx;
	logic [6:0] cfg_wdata;

	wall_scoreboard sb;
	int idle_cycles;
	bit burst;

	maze_wall_union_find_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.wall_row(wall_row),
		.wall_col(wall_col),
		.done(done),
		.outcome(outcome),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each outcome, note each accepted request and register write
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_outcome(outcome);
			if (start && !busy) sb.note_request(wall_row, wall_col);
			if (cfg_we) sb.note_config(cfg_idx, cfg_wdata);
			if (done || (start && !busy) || cfg_we) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Idle for the given gap, then hold the request until the unit takes it
	task automatic send_wall(input bit [6:0] r, input bit [6:0] c, input int gap);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		wall_row = r;
		wall_col = c;
		forever begin
			@(posedge clk);
			if (busy === 1'b0) break;
		end
	endtask

	// Drop start and wait until every outcome is in and the unit is idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		forever begin
			@(posedge clk);
			if (sb.pending() == 0 && busy === 1'b0) break;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_grid(input bit [6:0] rows_val, input bit [6:0] cols_val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = CFG_GRID_ROWS;
		cfg_wdata = rows_val;
		@(negedge clk);
		cfg_idx = CFG_GRID_COLS;
		cfg_wdata = cols_val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Reconfigure the grid, then send mostly real walls with some noise
	task automatic run_phase(input bit [6:0] rows_val, input bit [6:0] cols_val, input int count);
		int rows, cols, hr, hc, roll, r, c, gap;
		bit can_h, can_v;
		drain();
		set_grid(rows_val, cols_val);
		rows = sb.grid_size(rows_val, GRID_ROWS_LIM);
		cols = sb.grid_size(cols_val, GRID_COLS_LIM);
		hr = rows / 2;
		hc = cols / 2;
		can_h = (hc >= 2);
		can_v = (hr >= 2);
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0) burst = ($urandom_range(0, 2) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 8 || !(can_h || can_v)) begin
				r = $urandom_range(0, 127);
				c = $urandom_range(0, 127);
			end else if (roll < 15) begin
				r = $urandom_range(0, rows - 1);
				c = $urandom_range(0, cols - 1);
			end else if (can_h && (!can_v || $urandom_range(0, 1) == 1)) begin
				r = 2 * $urandom_range(0, hr - 1) + 1;
				c = 2 * $urandom_range(1, hc - 1);
			end else begin
				r = 2 * $urandom_range(1, hr - 1);
				c = 2 * $urandom_range(0, hc - 1) + 1;
			end
			gap = burst ? 0 : $urandom_range(0, 12);
			send_wall(7'(r), 7'(c), gap);
		end
	endtask

	initial begin
		bit [6:0] dir_row [20] = '{7'd0, 7'd127, 7'd65, 7'd3, 7'd64, 7'd63, 7'd1, 7'd2,
			7'd1, 7'd1, 7'd2, 7'd2, 7'd3, 7'd63, 7'd62, 7'd64, 7'd0, 7'd127, 7'd1, 7'd5};
		bit [6:0] dir_col [20] = '{7'd0, 7'd127, 7'd3, 7'd65, 7'd63, 7'd64, 7'd1, 7'd2,
			7'd2, 7'd2, 7'd1, 7'd3, 7'd2, 7'd62, 7'd63, 7'd64, 7'd127, 7'd0, 7'd64, 7'd0};
		arst_n = 1'b0;
		start = 1'b0;
		wall_row = '0;
		wall_col = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_GRID_ROWS;
		cfg_wdata = '0;
		idle_cycles = 0;
		burst = 1'b0;
		sb = new();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, borders, room, joint, joins, reopen, cycle
		drain();
		for (int i = 0; i < 20; i++) begin
			send_wall(dir_row[i], dir_col[i], $urandom_range(0, 12));
		end

		// Grid settings ranging from the smallest to the clamped largest
		run_phase(7'd127, 7'd2, 60);
		run_phase(7'd9, 7'd9, 110);
		run_phase(7'd3, 7'd65, 60);
		run_phase(7'd0, 7'd0, 20);
		run_phase(7'd66, 7'd64, 140);
		run_phase(7'd17, 7'd17, 110);
		run_phase(7'd65, 7'd65, 130);

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
